@@ hdl/frl_pkg.sv @@
`timescale 1ns / 1ps

package frl_pkg;

  // Fixed field widths of the pixel stream and the frame registers
  localparam int FRAME_BITS    = 12;
  localparam int ADDR_BITS     = 22;
  localparam int COLOR_BITS    = 24;
  localparam int CFG_ADDR_BITS = 4;

  // Reset value of both frame size registers
  localparam logic [FRAME_BITS-1:0] FRAME_SIZE_RESET = FRAME_BITS'(600);

  // Configuration register indexes
  localparam logic [CFG_ADDR_BITS-1:0] REG_FRAME_WIDTH  = CFG_ADDR_BITS'(0);
  localparam logic [CFG_ADDR_BITS-1:0] REG_FRAME_HEIGHT = CFG_ADDR_BITS'(1);

  // Input item opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;   // latch a new line and start the slope divide
    logic step;   // emit the current pixel and advance
  } frl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic div_done;    // slope is ready, line may start stepping
    logic last_pixel;  // current pixel is the final one of the line
    logic out_room;    // output register can take a pixel this cycle
  } frl_status_t;

endpackage

@@ hdl/frl_div.sv @@
`timescale 1ns / 1ps

// Restoring divider for the line slope: quo = (num << FRAC_BITS) / den.
// num <= den always holds, so the quotient has FRAC_BITS+1 bits and one
// quotient bit is produced per cycle. A zero divisor gives a zero quotient.
module frl_div #(
  parameter int NUM_BITS  = 12,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_BITS-1:0]  num,
  input  logic [NUM_BITS-1:0]  den,
  output logic                 done,
  output logic [FRAC_BITS:0]   quo
);

  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic [NUM_BITS:0]   rem_r, rem_nxt;
  logic [NUM_BITS-1:0] den_r;
  logic [FRAC_BITS:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;

  logic                ge;
  logic [NUM_BITS:0]   diff;
  logic [NUM_BITS:0]   kept;

  // One trial subtract per cycle
  assign ge   = (den_r != '0) && (rem_r >= {1'b0, den_r});
  assign diff = rem_r - {1'b0, den_r};
  assign kept = ge ? diff : rem_r;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = {1'b0, num};
      quo_nxt  = '0;
      cnt_nxt  = CNT_W'(FRAC_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // remainder stays below den, so the shifted value fits
      rem_nxt = {kept[NUM_BITS-1:0], 1'b0};
      quo_nxt = {quo_r[FRAC_BITS-1:0], ge};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

@@ hdl/frl_dp.sv @@
`timescale 1ns / 1ps

// Line datapath: endpoint setup, slope divider, DDA stepping, pixel
// address and clipping, the output register and the frame registers.
module frl_dp #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  frl_pkg::frl_cmd_t                   cmd,
  output frl_pkg::frl_status_t                status,
  // line endpoints and color, used on load
  input  logic [COORD_BITS-1:0]               x_start,
  input  logic [COORD_BITS-1:0]               y_start,
  input  logic [COORD_BITS-1:0]               x_end,
  input  logic [COORD_BITS-1:0]               y_end,
  input  logic [frl_pkg::COLOR_BITS-1:0]      line_color,
  // frame register writes
  input  logic                                cfg_we,
  input  logic [frl_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [frl_pkg::FRAME_BITS-1:0]      cfg_data,
  // pixel result
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [COORD_BITS-1:0]               pixel_x,
  output logic [COORD_BITS-1:0]               pixel_y,
  output logic [frl_pkg::ADDR_BITS-1:0]       pixel_addr,
  output logic [frl_pkg::COLOR_BITS-1:0]      pixel_color,
  output logic                                on_screen,
  output logic                                last
);

  localparam int C     = COORD_BITS;
  localparam int ACC_W = COORD_BITS + FRAC_BITS;
  localparam int FB    = frl_pkg::FRAME_BITS;
  localparam int CMP_W = (COORD_BITS > frl_pkg::FRAME_BITS) ? COORD_BITS
                                                           : frl_pkg::FRAME_BITS;

  // Frame registers
  logic [FB-1:0] frame_width_r, frame_height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= frl_pkg::FRAME_SIZE_RESET;
      frame_height_r <= frl_pkg::FRAME_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        frl_pkg::REG_FRAME_WIDTH:  frame_width_r  <= cfg_data;
        frl_pkg::REG_FRAME_HEIGHT: frame_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Line setup: deltas, major axis, length
  logic [C:0]   dx, dy;
  logic [C-1:0] x_len, y_len, major_len, minor_mag;
  logic         x_major;

  assign dx      = {x_end[C-1], x_end} - {x_start[C-1], x_start};
  assign dy      = {y_end[C-1], y_end} - {y_start[C-1], y_start};
  assign x_len   = dx[C] ? C'(-dx) : dx[C-1:0];
  assign y_len   = dy[C] ? C'(-dy) : dy[C-1:0];
  assign x_major = (x_len >= y_len);
  assign major_len = x_major ? x_len : y_len;
  assign minor_mag = x_major ? y_len : x_len;

  // Slope divider
  logic             div_done;
  logic [FRAC_BITS:0] div_quo;

  frl_div #(
    .NUM_BITS  (COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.load),
    .num   (minor_mag),
    .den   (major_len),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Line state
  logic             x_major_r;
  logic             major_neg_r;
  logic             slope_neg_r;
  logic [C-1:0]     major_pos_r;
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] slope_r;
  logic [C:0]       pixels_left_r;
  logic [frl_pkg::COLOR_BITS-1:0] color_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_major_r     <= x_major;
      major_neg_r   <= x_major ? dx[C] : dy[C];
      slope_neg_r   <= x_major ? dy[C] : dx[C];
      major_pos_r   <= x_major ? x_start : y_start;
      acc_r         <= {(x_major ? y_start : x_start), {FRAC_BITS{1'b0}}};
      pixels_left_r <= {1'b0, major_len} + (C+1)'(1);
      color_r       <= line_color;
    end else if (cmd.step) begin
      major_pos_r   <= major_pos_r + {{(C-1){major_neg_r}}, 1'b1};
      acc_r         <= acc_r + slope_r;
      pixels_left_r <= pixels_left_r - (C+1)'(1);
    end
    if (div_done) begin
      slope_r <= slope_neg_r ? ACC_W'(-ACC_W'(div_quo)) : ACC_W'(div_quo);
    end
  end

  // Current pixel: minor coordinate is the floored accumulator
  logic [C-1:0]     minor_pos, px, py;
  logic             vis;
  logic [FB+C-1:0]  row_base;
  logic [frl_pkg::ADDR_BITS-1:0] addr;

  assign minor_pos = acc_r[ACC_W-1:FRAC_BITS];
  assign px        = x_major_r ? major_pos_r : minor_pos;
  assign py        = x_major_r ? minor_pos : major_pos_r;
  assign vis       = !px[C-1] && !py[C-1] &&
                     (CMP_W'(px) < CMP_W'(frame_width_r)) &&
                     (CMP_W'(py) < CMP_W'(frame_height_r));
  assign row_base  = frame_width_r * py;
  assign addr      = frl_pkg::ADDR_BITS'(row_base) + frl_pkg::ADDR_BITS'(px);

  // Output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      pixel_x     <= px;
      pixel_y     <= py;
      pixel_addr  <= vis ? addr : '0;
      pixel_color <= color_r;
      on_screen   <= vis;
      last        <= (pixels_left_r <= (C+1)'(1));
    end
  end

  assign out_valid         = out_valid_r;
  assign status.div_done   = div_done;
  assign status.last_pixel = (pixels_left_r <= (C+1)'(1));
  assign status.out_room   = !out_valid_r || out_ready;

endmodule

@@ hdl/frl_ctrl.sv @@
`timescale 1ns / 1ps

// Line controller: idle, slope setup, and pixel stepping.
module frl_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_op,
  output logic                  in_ready,
  input  frl_pkg::frl_status_t  status,
  output frl_pkg::frl_cmd_t     cmd
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SETUP  = 2'd1;
  localparam logic [1:0] ST_ACTIVE = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       accept;

  // Steps wait for room in the output register while a line runs
  always_comb begin
    case (state_r)
      ST_IDLE:   in_ready = 1'b1;
      ST_ACTIVE: in_ready = status.out_room;
      default:   in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // a step with no line is dropped
        if (accept && in_op == frl_pkg::OP_LOAD) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (status.div_done) begin
          state_nxt = ST_ACTIVE;
        end
      end
      ST_ACTIVE: begin
        if (accept && in_op == frl_pkg::OP_LOAD) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end else if (accept) begin
          cmd.step = 1'b1;
          if (status.last_pixel) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hdl/fixed_point_line_rasterizer.sv @@
`timescale 1ns / 1ps
// Load item: accepted, then the slope is set up (the divider gives one quotient bit
//   a cycle, then the slope is latched) before steps are taken.
// Step item: one a cycle while a line is active and the output has room; its pixel
//   appears on the output register next cycle. Idle steps are accepted and dropped.
// Reset (rst_n low, synchronous): no line active, output empty, frame size 600x600.
module fixed_point_line_rasterizer #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input items
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // x_start, y_start, x_end, y_end, line_color from the lowest bit up
  input  logic [((4*COORD_BITS+frl_pkg::COLOR_BITS+7)/8)*8-1:0] in_tdata,
  // op
  input  logic                               in_tuser,
  // result items
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // pixel_x, pixel_y, pixel_addr, pixel_color from the lowest bit up
  output logic [((2*COORD_BITS+frl_pkg::ADDR_BITS+frl_pkg::COLOR_BITS+7)/8)*8-1:0] out_tdata,
  // on_screen
  output logic                               out_tuser,
  // last
  output logic                               out_tlast,
  // configuration writes
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [frl_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
  input  logic [frl_pkg::FRAME_BITS-1:0]     cfg_data
);

  localparam int C       = COORD_BITS;
  localparam int OUT_W   = ((2*C + frl_pkg::ADDR_BITS + frl_pkg::COLOR_BITS + 7) / 8) * 8;

  frl_pkg::frl_cmd_t    cmd;
  frl_pkg::frl_status_t status;

  logic [C-1:0]                    pixel_x, pixel_y;
  logic [frl_pkg::ADDR_BITS-1:0]   pixel_addr;
  logic [frl_pkg::COLOR_BITS-1:0]  pixel_color;

  assign cfg_ready = 1'b1;

  frl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser),
    .in_ready (in_tready),
    .status   (status),
    .cmd      (cmd)
  );

  frl_dp #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .x_start     (in_tdata[C-1:0]),
    .y_start     (in_tdata[2*C-1:C]),
    .x_end       (in_tdata[3*C-1:2*C]),
    .y_end       (in_tdata[4*C-1:3*C]),
    .line_color  (in_tdata[4*C+frl_pkg::COLOR_BITS-1:4*C]),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_addr    (cfg_addr),
    .cfg_data    (cfg_data),
    .out_ready   (out_tready),
    .out_valid   (out_tvalid),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_addr  (pixel_addr),
    .pixel_color (pixel_color),
    .on_screen   (out_tuser),
    .last        (out_tlast)
  );

  // Pack the pixel fields, zero fill to whole bytes
  assign out_tdata = OUT_W'({pixel_color, pixel_addr, pixel_y, pixel_x});

endmodule
